@@ rtl/tgfc_pkg.sv @@
// Shared constants, codes and command/status types of the tile grid factor chooser.
package tgfc_pkg;

   localparam int MAX_TILES = 64;

   localparam int COUNT_W  = 7;
   localparam int ASPECT_W = 32;
   localparam int FRAC_W   = 16;
   localparam int INDEX_W  = COUNT_W + 1;
   localparam int DIST_W   = COUNT_W + ASPECT_W;
   localparam int SPLIT_W  = 20;
   localparam int HI_W     = DIST_W - SPLIT_W;
   localparam int PP_W     = DIST_W + SPLIT_W;
   localparam int WIDE_W   = 2 * DIST_W;

   localparam int COUNT_MAX_VALUE = (1 << COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT =
      COUNT_W'((MAX_TILES > COUNT_MAX_VALUE) ? COUNT_MAX_VALUE : MAX_TILES);
   localparam logic [ASPECT_W-1:0] ASPECT_ONE = ASPECT_W'(1 << FRAC_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL_Q,
      ST_ORDER,
      ST_LHS_LO,
      ST_LHS_HI,
      ST_RHS_LO,
      ST_RHS_HI,
      ST_CMP
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_STEP,
      OP_MUL_Q,
      OP_ORDER,
      OP_LHS_LO,
      OP_LHS_HI,
      OP_RHS_LO,
      OP_RHS_HI,
      OP_UPDATE,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic pair_hit;
   } status_type;

endpackage

@@ rtl/tile_grid_factor_chooser_unit.sv @@
// Top level of the tile grid factor chooser: controller and datapath.
//
// An item is taken when start is high and busy is low; busy then stays high until
// the answer is ready, and the answer shows on rsp_column_count and rsp_row_count
// for one cycle with rsp_strobe, which the receiver must take as it comes. A count
// of zero gives 1x1, counts above the tile limit are clamped, and an aspect of zero
// counts as 1.0. The time an item takes is set by the factor walk, which moves one
// column or one row per cycle and pauses while a factor pair is compared, and by the
// single shared 39x20 multiplier, which needs five passes per factor pair for the
// exact cross-multiplied distance compare.
module tile_grid_factor_chooser_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tgfc_pkg::COUNT_W-1:0]      req_tile_count,
   input  logic [tgfc_pkg::ASPECT_W-1:0]     req_aspect_ratio,
   output logic                              rsp_strobe,
   output logic [tgfc_pkg::COUNT_W-1:0]      rsp_column_count,
   output logic [tgfc_pkg::COUNT_W-1:0]      rsp_row_count
);

   tgfc_pkg::cmd_type    cmd;
   tgfc_pkg::status_type status;

   tgfc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   tgfc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_tile_count   (req_tile_count),
      .req_aspect_ratio (req_aspect_ratio),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_column_count (rsp_column_count),
      .rsp_row_count    (rsp_row_count)
   );

endmodule

@@ rtl/tgfc_ctrl.sv @@
// Controller state machine of the tile grid factor chooser.
module tgfc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  tgfc_pkg::status_type status,
   output tgfc_pkg::cmd_type    cmd,
   output logic                 busy
);

   tgfc_pkg::state_type state_ff;
   tgfc_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tgfc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tgfc_pkg::ST_SCAN;
            end
         end
         tgfc_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = tgfc_pkg::ST_IDLE;
            end else if (status.pair_hit) begin
               state_in = tgfc_pkg::ST_MUL_Q;
            end
         end
         tgfc_pkg::ST_MUL_Q:  state_in = tgfc_pkg::ST_ORDER;
         tgfc_pkg::ST_ORDER:  state_in = tgfc_pkg::ST_LHS_LO;
         tgfc_pkg::ST_LHS_LO: state_in = tgfc_pkg::ST_LHS_HI;
         tgfc_pkg::ST_LHS_HI: state_in = tgfc_pkg::ST_RHS_LO;
         tgfc_pkg::ST_RHS_LO: state_in = tgfc_pkg::ST_RHS_HI;
         tgfc_pkg::ST_RHS_HI: state_in = tgfc_pkg::ST_CMP;
         tgfc_pkg::ST_CMP:    state_in = tgfc_pkg::ST_SCAN;
         default:             state_in = tgfc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = tgfc_pkg::OP_NONE;
      busy   = 1'b1;
      case (state_ff)
         tgfc_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.op = tgfc_pkg::OP_LOAD;
            end
         end
         tgfc_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               cmd.op = tgfc_pkg::OP_FINISH;
            end else if (!status.pair_hit) begin
               cmd.op = tgfc_pkg::OP_STEP;
            end
         end
         tgfc_pkg::ST_MUL_Q:  cmd.op = tgfc_pkg::OP_MUL_Q;
         tgfc_pkg::ST_ORDER:  cmd.op = tgfc_pkg::OP_ORDER;
         tgfc_pkg::ST_LHS_LO: cmd.op = tgfc_pkg::OP_LHS_LO;
         tgfc_pkg::ST_LHS_HI: cmd.op = tgfc_pkg::OP_LHS_HI;
         tgfc_pkg::ST_RHS_LO: cmd.op = tgfc_pkg::OP_RHS_LO;
         tgfc_pkg::ST_RHS_HI: cmd.op = tgfc_pkg::OP_RHS_HI;
         tgfc_pkg::ST_CMP:    cmd.op = tgfc_pkg::OP_UPDATE;
         default:             cmd.op = tgfc_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tgfc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/tgfc_dp.sv @@
// Datapath of the tile grid factor chooser: factor walk, shared multiplier, best pair.
module tgfc_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  tgfc_pkg::cmd_type                 cmd,
   input  logic [tgfc_pkg::COUNT_W-1:0]      req_tile_count,
   input  logic [tgfc_pkg::ASPECT_W-1:0]     req_aspect_ratio,
   output tgfc_pkg::status_type              status,
   output logic                              rsp_strobe,
   output logic [tgfc_pkg::COUNT_W-1:0]      rsp_column_count,
   output logic [tgfc_pkg::COUNT_W-1:0]      rsp_row_count
);

   localparam int CW = tgfc_pkg::COUNT_W;
   localparam int IW = tgfc_pkg::INDEX_W;
   localparam int DW = tgfc_pkg::DIST_W;
   localparam int SW = tgfc_pkg::SPLIT_W;
   localparam int PW = tgfc_pkg::PP_W;
   localparam int WW = tgfc_pkg::WIDE_W;

   logic [CW-1:0]                     n_ff, n_in;
   logic [tgfc_pkg::ASPECT_W-1:0]     aspect_ff, aspect_in;
   logic [IW-1:0]                     a_ff, a_in;
   logic [CW-1:0]                     b_ff, b_in;
   logic [IW-1:0]                     prod_ff, prod_in;
   logic [DW-1:0]                     q_ff, q_in;
   logic [DW-1:0]                     big_ff, big_in;
   logic [DW-1:0]                     small_ff, small_in;
   logic [DW-1:0]                     best_big_ff, best_big_in;
   logic [DW-1:0]                     best_small_ff, best_small_in;
   logic [CW-1:0]                     best_c_ff, best_c_in;
   logic [CW-1:0]                     best_r_ff, best_r_in;
   logic [PW-1:0]                     pp_ff, pp_in;
   logic [PW-1:0]                     lo_ff, lo_in;
   logic [WW-1:0]                     lhs_ff, lhs_in;
   logic [CW-1:0]                     col_ff, col_in;
   logic [CW-1:0]                     row_ff, row_in;
   logic                              first_ff, first_in;
   logic                              strobe_ff, strobe_in;

   logic [DW-1:0]                     mul_x;
   logic [SW-1:0]                     mul_y;
   logic [PW-1:0]                     mul_p;
   logic [WW-1:0]                     wide_sum;
   logic [DW-1:0]                     p_scaled;
   logic [CW-1:0]                     load_n;
   logic                              do_step;
   logic                              take;

   always_comb begin
      mul_x = '0;
      mul_y = '0;
      case (cmd.op)
         tgfc_pkg::OP_MUL_Q: begin
            mul_x = DW'(aspect_ff);
            mul_y = SW'(b_ff);
         end
         tgfc_pkg::OP_LHS_LO: begin
            mul_x = big_ff;
            mul_y = best_small_ff[SW-1:0];
         end
         tgfc_pkg::OP_LHS_HI: begin
            mul_x = big_ff;
            mul_y = SW'(best_small_ff[DW-1:SW]);
         end
         tgfc_pkg::OP_RHS_LO: begin
            mul_x = best_big_ff;
            mul_y = small_ff[SW-1:0];
         end
         tgfc_pkg::OP_RHS_HI: begin
            mul_x = best_big_ff;
            mul_y = SW'(small_ff[DW-1:SW]);
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign mul_p    = PW'(mul_x) * PW'(mul_y);
   assign wide_sum = WW'(lo_ff) + (WW'(pp_ff) << SW);
   assign p_scaled = DW'(a_ff) << tgfc_pkg::FRAC_W;
   assign take     = first_ff || (lhs_ff < wide_sum);
   assign do_step  = (cmd.op == tgfc_pkg::OP_STEP) || (cmd.op == tgfc_pkg::OP_UPDATE);

   always_comb begin
      if (req_tile_count == '0) begin
         load_n = CW'(1);
      end else if (req_tile_count > tgfc_pkg::COUNT_LIMIT) begin
         load_n = tgfc_pkg::COUNT_LIMIT;
      end else begin
         load_n = req_tile_count;
      end
   end

   assign status.scan_done = a_ff > IW'(n_ff);
   assign status.pair_hit  = prod_ff == IW'(n_ff);

   always_comb begin
      n_in          = n_ff;
      aspect_in     = aspect_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      prod_in       = prod_ff;
      q_in          = q_ff;
      big_in        = big_ff;
      small_in      = small_ff;
      best_big_in   = best_big_ff;
      best_small_in = best_small_ff;
      best_c_in     = best_c_ff;
      best_r_in     = best_r_ff;
      pp_in         = pp_ff;
      lo_in         = lo_ff;
      lhs_in        = lhs_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      first_in      = first_ff;
      strobe_in     = 1'b0;

      case (cmd.op)
         tgfc_pkg::OP_LOAD: begin
            n_in      = load_n;
            aspect_in = (req_aspect_ratio == '0) ? tgfc_pkg::ASPECT_ONE : req_aspect_ratio;
            a_in      = IW'(1);
            b_in      = load_n;
            prod_in   = IW'(load_n);
            first_in  = 1'b1;
         end
         tgfc_pkg::OP_MUL_Q: begin
            q_in = DW'(mul_p);
         end
         tgfc_pkg::OP_ORDER: begin
            if (p_scaled >= q_ff) begin
               big_in   = p_scaled;
               small_in = q_ff;
            end else begin
               big_in   = q_ff;
               small_in = p_scaled;
            end
         end
         tgfc_pkg::OP_LHS_LO: begin
            pp_in = mul_p;
         end
         tgfc_pkg::OP_LHS_HI: begin
            pp_in = mul_p;
            lo_in = pp_ff;
         end
         tgfc_pkg::OP_RHS_LO: begin
            lhs_in = wide_sum;
            pp_in  = mul_p;
         end
         tgfc_pkg::OP_RHS_HI: begin
            pp_in = mul_p;
            lo_in = pp_ff;
         end
         tgfc_pkg::OP_UPDATE: begin
            if (take) begin
               best_c_in     = a_ff[CW-1:0];
               best_r_in     = b_ff;
               best_big_in   = big_ff;
               best_small_in = small_ff;
               first_in      = 1'b0;
            end
         end
         tgfc_pkg::OP_FINISH: begin
            col_in    = best_c_ff;
            row_in    = best_r_ff;
            strobe_in = 1'b1;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase

      // advance the factor walk: drop rows while over the count, else add a column
      if (do_step) begin
         if (prod_ff > IW'(n_ff)) begin
            b_in    = b_ff - CW'(1);
            prod_in = prod_ff - a_ff;
         end else begin
            a_in    = a_ff + IW'(1);
            prod_in = prod_ff + IW'(b_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         first_ff  <= first_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      aspect_ff     <= aspect_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      prod_ff       <= prod_in;
      q_ff          <= q_in;
      big_ff        <= big_in;
      small_ff      <= small_in;
      best_big_ff   <= best_big_in;
      best_small_ff <= best_small_in;
      best_c_ff     <= best_c_in;
      best_r_ff     <= best_r_in;
      pp_ff         <= pp_in;
      lo_ff         <= lo_in;
      lhs_ff        <= lhs_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_column_count = col_ff;
   assign rsp_row_count    = row_ff;

endmodule

@@ rtl/tgfc_checker.sv @@
// Port-level checker of the tile grid factor chooser, bound to the top level.
module tgfc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [tgfc_pkg::COUNT_W-1:0]      req_tile_count,
   input logic                              rsp_strobe,
   input logic [tgfc_pkg::COUNT_W-1:0]      rsp_column_count,
   input logic [tgfc_pkg::COUNT_W-1:0]      rsp_row_count
);

   localparam int CW = tgfc_pkg::COUNT_W;

   logic [CW-1:0]   expect_ff, expect_in;
   logic [2*CW-1:0] grid_size;

   always_comb begin
      expect_in = expect_ff;
      if (start && !busy) begin
         if (req_tile_count == '0) begin
            expect_in = CW'(1);
         end else if (req_tile_count > tgfc_pkg::COUNT_LIMIT) begin
            expect_in = tgfc_pkg::COUNT_LIMIT;
         end else begin
            expect_in = req_tile_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= CW'(1);
      end else begin
         expect_ff <= expect_in;
      end
   end

   assign grid_size = (2*CW)'(rsp_column_count) * (2*CW)'(rsp_row_count);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after an accepted item");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while still busy");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_grid_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> grid_size == (2*CW)'(expect_ff))
      else $error("columns times rows differ from the tile count");

endmodule

bind tile_grid_factor_chooser_unit tgfc_checker u_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the tile grid factor chooser: directed and random items.
module testbench;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int RANDOM_ITEMS   = 1200;

   typedef struct packed {
      logic [tgfc_pkg::COUNT_W-1:0] cols;
      logic [tgfc_pkg::COUNT_W-1:0] rows;
   } grid_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [tgfc_pkg::COUNT_W-1:0]  req_tile_count;
   logic [tgfc_pkg::ASPECT_W-1:0] req_aspect_ratio;
   logic                          rsp_strobe;
   logic [tgfc_pkg::COUNT_W-1:0]  rsp_column_count;
   logic [tgfc_pkg::COUNT_W-1:0]  rsp_row_count;

   grid_type pending_grids[$];
   int       failures = 0;
   int       quiet_cycles = 0;
   bit       steady_sender = 1'b0;

   tile_grid_factor_chooser_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_tile_count   (req_tile_count),
      .req_aspect_ratio (req_aspect_ratio),
      .rsp_strobe       (rsp_strobe),
      .rsp_column_count (rsp_column_count),
      .rsp_row_count    (rsp_row_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic grid_type choose_grid(input logic [tgfc_pkg::COUNT_W-1:0]  count,
                                            input logic [tgfc_pkg::ASPECT_W-1:0] aspect);
      grid_type    best;
      int          n;
      logic [63:0] target;
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] dist_hi;
      logic [63:0] dist_lo;
      logic [63:0] best_hi;
      logic [63:0] best_lo;
      best.cols = tgfc_pkg::COUNT_W'(1);
      best.rows = tgfc_pkg::COUNT_W'(1);
      best_hi = '0;
      best_lo = '0;
      if (count == '0) return best;
      n = (int'(count) > tgfc_pkg::MAX_TILES) ? tgfc_pkg::MAX_TILES : int'(count);
      target = (aspect == '0) ? 64'(tgfc_pkg::ASPECT_ONE) : 64'(aspect);
      for (int c = 1; c <= n; c++) begin
         if (n % c == 0) begin
            p = 64'(c) << tgfc_pkg::FRAC_W;
            q = 64'(n / c) * target;
            if (p >= q) begin
               dist_hi = p;
               dist_lo = q;
            end else begin
               dist_hi = q;
               dist_lo = p;
            end
            // keep the earlier pair unless strictly closer
            if (c == 1 || 128'(dist_hi) * 128'(best_lo) < 128'(best_hi) * 128'(dist_lo)) begin
               best.cols = tgfc_pkg::COUNT_W'(c);
               best.rows = tgfc_pkg::COUNT_W'(n / c);
               best_hi = dist_hi;
               best_lo = dist_lo;
            end
         end
      end
      return best;
   endfunction

   task automatic send_item(input logic [tgfc_pkg::COUNT_W-1:0]  count,
                            input logic [tgfc_pkg::ASPECT_W-1:0] aspect);
      int gap;
      gap = steady_sender ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tile_count   <= count;
      req_aspect_ratio <= aspect;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      pending_grids.push_back(choose_grid(count, aspect));
   endtask

   always @(posedge clock) begin
      grid_type want;
      if (!reset && rsp_strobe) begin
         if (pending_grids.size() == 0) begin
            $display("%0t: unexpected item cols=%0d rows=%0d", $time,
                     rsp_column_count, rsp_row_count);
            failures++;
         end else begin
            want = pending_grids.pop_front();
            if (rsp_column_count !== want.cols) begin
               $display("%0t: column_count expected %0d actual %0d", $time,
                        want.cols, rsp_column_count);
               failures++;
            end
            if (rsp_row_count !== want.rows) begin
               $display("%0t: row_count expected %0d actual %0d", $time,
                        want.rows, rsp_row_count);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic test_zero_count();
      send_item(7'd0, 32'h0000_0000);
      send_item(7'd0, 32'hFFFF_FFFF);
      send_item(7'd0, tgfc_pkg::ASPECT_ONE);
   endtask

   task automatic test_field_extremes();
      send_item(7'd1, 32'h0000_0000);
      send_item(7'd64, 32'h0000_0000);
      send_item(7'd127, 32'hFFFF_FFFF);
      send_item(7'd65, 32'h0000_0001);
      send_item(7'd64, 32'h0000_0001);
      send_item(7'd64, 32'hFFFF_FFFF);
      send_item(7'd36, tgfc_pkg::ASPECT_ONE);
      send_item(7'd12, 32'h0000_0001);
   endtask

   task automatic test_prime_counts();
      send_item(7'd2, tgfc_pkg::ASPECT_ONE);
      send_item(7'd13, tgfc_pkg::ASPECT_ONE);
      send_item(7'd61, 32'h003D_0000);
      send_item(7'd61, 32'h0000_0000);
      send_item(7'd3, 32'h0000_8000);
   endtask

   task automatic test_ratio_ties();
      send_item(7'd8, tgfc_pkg::ASPECT_ONE);
      send_item(7'd6, 32'h0001_8000);
      send_item(7'd24, 32'h0002_0000);
      send_item(7'd32, 32'h0002_0000);
      send_item(7'd64, 32'h0000_4000);
   endtask

   task automatic test_random_items();
      logic [tgfc_pkg::COUNT_W-1:0]  count;
      logic [tgfc_pkg::ASPECT_W-1:0] aspect;
      int                            pick;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0) steady_sender = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         if (pick == 0) count = '0;
         else if (pick < 4) count = tgfc_pkg::COUNT_W'($urandom_range(65, 127));
         else count = tgfc_pkg::COUNT_W'($urandom_range(1, 64));
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3: aspect = $urandom;
            4, 5, 6: aspect = tgfc_pkg::ASPECT_W'(($urandom_range(1, 64) << tgfc_pkg::FRAC_W) /
                                                  $urandom_range(1, 64));
            7: aspect = tgfc_pkg::ASPECT_W'($urandom_range(0, 255));
            8: aspect = '0;
            default: aspect = tgfc_pkg::ASPECT_ONE +
                              tgfc_pkg::ASPECT_W'($urandom_range(0, 31)) -
                              tgfc_pkg::ASPECT_W'(16);
         endcase
         send_item(count, aspect);
      end
      steady_sender = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_tile_count   = '0;
      req_aspect_ratio = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_count();
      test_field_extremes();
      test_prime_counts();
      test_ratio_ties();
      test_random_items();

      @(negedge clock);
      start <= 1'b0;
      wait (pending_grids.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending_grids.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tgfc_pkg.sv
rtl/tgfc_ctrl.sv
rtl/tgfc_dp.sv
rtl/tile_grid_factor_chooser_unit.sv
rtl/tgfc_checker.sv
test/testbench.sv
